[sv/otb_pkg.sv]
`default_nettype none

package otb_pkg;

    // frame geometry and derived widths
    localparam int FRAME_WIDTH  = 188;
    localparam int FRAME_HEIGHT = 120;
    localparam int PIXEL_CAP    = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int PIX_W        = 8;
    localparam int BINS         = 256;
    localparam int PIX_MAX      = 255;
    localparam int CNT_W        = $clog2(PIXEL_CAP + 1);
    localparam int GRAY_W       = $clog2(PIXEL_CAP * PIX_MAX + 1);
    localparam int P_W          = GRAY_W + CNT_W;
    localparam int DEN_W        = 2 * CNT_W;
    localparam int SQ_W         = 2 * P_W;
    localparam int MA_W         = SQ_W + DEN_W;
    localparam int MB_W         = P_W;
    localparam int DIGIT_W      = 4;

    // request codes
    localparam logic OP_ACCUMULATE  = 1'b0;
    localparam logic OP_BINARIZE    = 1'b1;
    localparam logic KIND_PIXEL     = 1'b0;
    localparam logic KIND_THRESHOLD = 1'b1;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC_READ,
        ST_ACC_WRITE,
        ST_SCAN_READ,
        ST_SCAN_LOAD,
        ST_SCAN_EVAL,
        ST_MUL_P,
        ST_MUL_Q,
        ST_MUL_D,
        ST_MUL_M2,
        ST_DECIDE,
        ST_MUL_L,
        ST_MUL_R,
        ST_NEXT,
        ST_FINISH,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        MUL_P,
        MUL_Q,
        MUL_D,
        MUL_M2,
        MUL_L,
        MUL_R
    } mul_sel_t;

    typedef struct packed {
        logic     acc_latch;
        logic     rd_scan;
        logic     wr_zero;
        logic     wr_inc;
        logic     tot_upd;
        logic     search_init;
        logic     scan_acc;
        logic     t_inc;
        logic     mul_load;
        mul_sel_t mul_load_sel;
        logic     mul_cap;
        mul_sel_t mul_cap_sel;
        logic     best_upd;
        logic     finish;
        logic     out_bin;
        logic     out_thr;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic cap_full;
        logic last_flag;
        logic mul_done;
        logic wb_zero;
        logic wb_full;
        logic best_zero;
        logic mag_zero;
        logic lhs_gt;
        logic t_last;
    } status_t;

endpackage

`default_nettype wire

[sv/otsu_binarize_frame.sv]
// Binarize request: taken when the output is free, result valid in the next cycle.
// Accumulate request: ST_ACC_READ, ST_ACC_WRITE (histogram RMW on one RAM port).
// Last accumulate: threshold search of up to 256 steps, each through ST_SCAN_READ,
// ST_SCAN_LOAD, ST_SCAN_EVAL and ST_NEXT, plus the digit-serial multiplier (4 bits
// per cycle) for a nonempty cut; then ST_FINISH and ST_EMIT. Reset: asynchronous,
// active low, then clears all 256 bins, taking no request. Threshold resets to 0.
`default_nettype none

module otsu_binarize_frame
    import otb_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_stall,
    input  wire              operation,
    input  wire  [PIX_W-1:0] pixel,
    input  wire              last,
    output logic             out_valid,
    input  wire              out_stall,
    output logic             kind,
    output logic [PIX_W-1:0] binary_pixel,
    output logic [PIX_W-1:0] threshold_value
);

    cmd_t    cmd;
    status_t status;

    otb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .last      (last),
        .status    (status),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    otb_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .pixel           (pixel),
        .last            (last),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .kind            (kind),
        .binary_pixel    (binary_pixel),
        .threshold_value (threshold_value)
    );

endmodule

`default_nettype wire

[sv/otb_ram.sv]
`default_nettype none

module otb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      clk,
    input  wire                      wr_en,
    input  wire  [$clog2(DEPTH)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]         wr_data,
    input  wire  [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[sv/otb_mul.sv]
`default_nettype none

module otb_mul
    import otb_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              load,
    input  wire  [MA_W-1:0]  a,
    input  wire  [MB_W-1:0]  b,
    output logic             done,
    output logic [MA_W-1:0]  product
);

    logic [MA_W-1:0] a_reg, a_next;
    logic [MB_W-1:0] b_reg, b_next;
    logic [MA_W-1:0] acc_reg, acc_next;
    logic [MA_W-1:0] partial;

    // one digit of b per cycle
    assign partial = a_reg * {{(MA_W - DIGIT_W){1'b0}}, b_reg[DIGIT_W-1:0]};
    assign done    = (b_reg == '0);
    assign product = acc_reg;

    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        acc_next = acc_reg;
        if (load)
        begin
            a_next   = a;
            b_next   = b;
            acc_next = '0;
        end
        else if (!done)
        begin
            acc_next = acc_reg + partial;
            a_next   = a_reg << DIGIT_W;
            b_next   = b_reg >> DIGIT_W;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
        end
        else
        begin
            b_reg <= b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        acc_reg <= acc_next;
    end

endmodule

`default_nettype wire

[sv/otb_datapath.sv]
`default_nettype none

module otb_datapath
    import otb_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  cmd_t             cmd,
    output status_t          status,
    input  wire  [PIX_W-1:0] pixel,
    input  wire              last,
    input  wire              out_stall,
    output logic             out_valid,
    output logic             kind,
    output logic [PIX_W-1:0] binary_pixel,
    output logic [PIX_W-1:0] threshold_value
);

    localparam int AW = $clog2(BINS);

    logic [AW-1:0]     pix_reg;
    logic              last_reg;
    logic [AW-1:0]     t_reg;
    logic [CNT_W-1:0]  pix_tot_reg;
    logic [GRAY_W-1:0] gray_tot_reg;
    logic [PIX_W-1:0]  thr_reg;
    logic [CNT_W-1:0]  wb_reg;
    logic [GRAY_W-1:0] sumb_reg;
    logic [P_W-1:0]    p_reg, q_reg, mag_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [SQ_W-1:0]   m2_reg;
    logic [MA_W-1:0]   lhs_reg;
    logic [P_W-1:0]    best_diff_reg;
    logic [DEN_W-1:0]  best_den_reg;
    logic [SQ_W-1:0]   best_sq_reg;
    logic [PIX_W-1:0]  best_t_reg;
    logic              out_valid_reg;
    logic              kind_reg;
    logic [PIX_W-1:0]  bin_pix_reg, thr_out_reg;

    logic              wr_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [CNT_W-1:0]  wr_data, rd_data;
    logic [P_W-1:0]    mag_comb;
    logic [CNT_W-1:0]  wf;
    logic [MA_W-1:0]   mul_a, mul_prod;
    logic [MB_W-1:0]   mul_b;
    logic              mul_done;

    // histogram store
    assign wr_en   = cmd.wr_zero | cmd.wr_inc;
    assign wr_addr = cmd.wr_inc ? pix_reg : t_reg;
    assign wr_data = cmd.wr_inc ? rd_data + CNT_W'(1) : '0;
    assign rd_addr = cmd.rd_scan ? t_reg : pix_reg;

    otb_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BINS)
    ) u_hist (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // operand select for the shared multiplier
    assign mag_comb = (p_reg >= q_reg) ? p_reg - q_reg : q_reg - p_reg;
    assign wf       = pix_tot_reg - wb_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_load_sel)
            MUL_P:
            begin
                mul_a = MA_W'(sumb_reg);
                mul_b = MB_W'(pix_tot_reg);
            end
            MUL_Q:
            begin
                mul_a = MA_W'(gray_tot_reg);
                mul_b = MB_W'(wb_reg);
            end
            MUL_D:
            begin
                mul_a = MA_W'(wb_reg);
                mul_b = MB_W'(wf);
            end
            MUL_M2:
            begin
                mul_a = MA_W'(mag_comb);
                mul_b = MB_W'(mag_comb);
            end
            MUL_L:
            begin
                mul_a = MA_W'(m2_reg);
                mul_b = MB_W'(best_den_reg);
            end
            MUL_R:
            begin
                mul_a = MA_W'(best_sq_reg);
                mul_b = MB_W'(den_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    otb_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (cmd.mul_load),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    // status back to the controller
    assign status.out_free  = !out_valid_reg || !out_stall;
    assign status.cap_full  = (pix_tot_reg >= CNT_W'(PIXEL_CAP));
    assign status.last_flag = last_reg;
    assign status.mul_done  = mul_done;
    assign status.wb_zero   = (wb_reg == '0);
    assign status.wb_full   = (wb_reg >= pix_tot_reg);
    assign status.best_zero = (best_diff_reg == '0);
    assign status.mag_zero  = (mag_reg == '0);
    assign status.lhs_gt    = (lhs_reg > mul_prod);
    assign status.t_last    = (t_reg == AW'(BINS - 1));

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg         <= '0;
            pix_tot_reg   <= '0;
            gray_tot_reg  <= '0;
            thr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.search_init)
            begin
                t_reg <= '0;
            end
            else if (cmd.t_inc)
            begin
                t_reg <= t_reg + AW'(1);
            end
            if (cmd.tot_upd)
            begin
                pix_tot_reg  <= pix_tot_reg + CNT_W'(1);
                gray_tot_reg <= gray_tot_reg + GRAY_W'(pix_reg);
            end
            else if (cmd.finish)
            begin
                pix_tot_reg  <= '0;
                gray_tot_reg <= '0;
            end
            if (cmd.finish)
            begin
                thr_reg <= best_t_reg;
            end
            if (cmd.out_bin || cmd.out_thr)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // search and output payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.acc_latch)
        begin
            pix_reg  <= pixel;
            last_reg <= last;
        end
        if (cmd.search_init)
        begin
            wb_reg        <= '0;
            sumb_reg      <= '0;
            best_diff_reg <= '0;
            best_den_reg  <= '0;
            best_t_reg    <= '0;
        end
        else if (cmd.scan_acc)
        begin
            wb_reg   <= wb_reg + rd_data;
            sumb_reg <= sumb_reg + GRAY_W'(t_reg) * GRAY_W'(rd_data);
        end
        if (cmd.mul_load && cmd.mul_load_sel == MUL_M2)
        begin
            mag_reg <= mag_comb;
        end
        if (cmd.mul_cap)
        begin
            unique case (cmd.mul_cap_sel)
                MUL_P:   p_reg   <= mul_prod[P_W-1:0];
                MUL_Q:   q_reg   <= mul_prod[P_W-1:0];
                MUL_D:   den_reg <= mul_prod[DEN_W-1:0];
                MUL_M2:  m2_reg  <= mul_prod[SQ_W-1:0];
                MUL_L:   lhs_reg <= mul_prod;
                default: lhs_reg <= lhs_reg;
            endcase
        end
        if (cmd.best_upd)
        begin
            best_diff_reg <= mag_reg;
            best_den_reg  <= den_reg;
            best_sq_reg   <= m2_reg;
            best_t_reg    <= t_reg;
        end
        if (cmd.out_bin)
        begin
            kind_reg    <= KIND_PIXEL;
            bin_pix_reg <= (pixel >= thr_reg) ? PIX_W'(PIX_MAX) : '0;
            thr_out_reg <= thr_reg;
        end
        else if (cmd.out_thr)
        begin
            kind_reg    <= KIND_THRESHOLD;
            bin_pix_reg <= '0;
            thr_out_reg <= thr_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign binary_pixel    = bin_pix_reg;
    assign threshold_value = thr_out_reg;

endmodule

`default_nettype wire

[sv/otb_ctrl.sv]
`default_nettype none

module otb_ctrl
    import otb_pkg::*;
(
    input  wire     clk,
    input  wire     rst_n,
    input  wire     in_valid,
    input  wire     operation,
    input  wire     last,
    input  status_t status,
    output logic    in_stall,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            // sweep the histogram to zero after reset
            ST_CLEAR:
            begin
                cmd.wr_zero = 1'b1;
                cmd.t_inc   = 1'b1;
                if (status.t_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            // take a request when the output side has room
            ST_IDLE:
            begin
                in_stall = !status.out_free;
                if (in_valid && status.out_free)
                begin
                    if (operation == OP_BINARIZE)
                    begin
                        cmd.out_bin = 1'b1;
                    end
                    else if (status.cap_full)
                    begin
                        if (last)
                        begin
                            cmd.search_init = 1'b1;
                            state_next      = ST_SCAN_READ;
                        end
                    end
                    else
                    begin
                        cmd.acc_latch = 1'b1;
                        state_next    = ST_ACC_READ;
                    end
                end
            end
            ST_ACC_READ:
            begin
                state_next = ST_ACC_WRITE;
            end
            // bump the bin and the totals
            ST_ACC_WRITE:
            begin
                cmd.wr_inc  = 1'b1;
                cmd.tot_upd = 1'b1;
                if (status.last_flag)
                begin
                    cmd.search_init = 1'b1;
                    state_next      = ST_SCAN_READ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_READ:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = ST_SCAN_LOAD;
            end
            // fold the bin into the background and clear it
            ST_SCAN_LOAD:
            begin
                cmd.scan_acc = 1'b1;
                cmd.wr_zero  = 1'b1;
                state_next   = ST_SCAN_EVAL;
            end
            ST_SCAN_EVAL:
            begin
                if (status.wb_zero)
                begin
                    state_next = ST_NEXT;
                end
                else if (status.wb_full)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.mul_load     = 1'b1;
                    cmd.mul_load_sel = MUL_P;
                    state_next       = ST_MUL_P;
                end
            end
            ST_MUL_P:
            begin
                if (status.mul_done)
                begin
                    cmd.mul_cap      = 1'b1;
                    cmd.mul_cap_sel  = MUL_P;
                    cmd.mul_load     = 1'b1;
                    cmd.mul_load_sel = MUL_Q;
                    state_next       = ST_MUL_Q;
                end
            end
            ST_MUL_Q:
            begin
                if (status.mul_done)
                begin
                    cmd.mul_cap      = 1'b1;
                    cmd.mul_cap_sel  = MUL_Q;
                    cmd.mul_load     = 1'b1;
                    cmd.mul_load_sel = MUL_D;
                    state_next       = ST_MUL_D;
                end
            end
            ST_MUL_D:
            begin
                if (status.mul_done)
                begin
                    cmd.mul_cap      = 1'b1;
                    cmd.mul_cap_sel  = MUL_D;
                    cmd.mul_load     = 1'b1;
                    cmd.mul_load_sel = MUL_M2;
                    state_next       = ST_MUL_M2;
                end
            end
            ST_MUL_M2:
            begin
                if (status.mul_done)
                begin
                    cmd.mul_cap     = 1'b1;
                    cmd.mul_cap_sel = MUL_M2;
                    state_next      = ST_DECIDE;
                end
            end
            // first nonzero variance wins outright, else cross-multiply
            ST_DECIDE:
            begin
                if (status.best_zero)
                begin
                    cmd.best_upd = !status.mag_zero;
                    state_next   = ST_NEXT;
                end
                else
                begin
                    cmd.mul_load     = 1'b1;
                    cmd.mul_load_sel = MUL_L;
                    state_next       = ST_MUL_L;
                end
            end
            ST_MUL_L:
            begin
                if (status.mul_done)
                begin
                    cmd.mul_cap      = 1'b1;
                    cmd.mul_cap_sel  = MUL_L;
                    cmd.mul_load     = 1'b1;
                    cmd.mul_load_sel = MUL_R;
                    state_next       = ST_MUL_R;
                end
            end
            ST_MUL_R:
            begin
                if (status.mul_done)
                begin
                    cmd.best_upd = status.lhs_gt;
                    state_next   = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (status.t_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.t_inc  = 1'b1;
                    state_next = ST_SCAN_READ;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_EMIT;
            end
            // hold until the output register is free
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_thr = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/otb_check.sv]
`default_nettype none

module otb_check
    import otb_pkg::*;
(
    input wire             clk,
    input wire             rst_n,
    input wire             in_valid,
    input wire             in_stall,
    input wire             out_valid,
    input wire             out_stall,
    input wire             kind,
    input wire [PIX_W-1:0] binary_pixel,
    input wire [PIX_W-1:0] threshold_value
);

    // stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind)
            && $stable(binary_pixel) && $stable(threshold_value))
        else $error("stalled result changed");

    // binarized pixel is black or white
    a_bin_levels: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_PIXEL |->
            binary_pixel == '0 || binary_pixel == PIX_W'(PIX_MAX))
        else $error("binarized pixel not 0 or 255");

    // threshold result carries a zero pixel
    a_thr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_THRESHOLD |-> binary_pixel == '0)
        else $error("threshold result with nonzero pixel");

    // no request taken while a stalled result waits
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("request taken while output blocked");

endmodule

bind otsu_binarize_frame otb_check u_otb_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .binary_pixel    (binary_pixel),
    .threshold_value (threshold_value)
);

`default_nettype wire

[bench/otsu_binarize_frame_test.sv]
`default_nettype none

module otsu_binarize_frame_test;
    import otb_pkg::*;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] binary_pixel;
        logic [PIX_W-1:0] threshold_value;
    } pix_result_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic             operation;
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic             out_valid;
    logic             out_stall;
    logic             kind;
    logic [PIX_W-1:0] binary_pixel;
    logic [PIX_W-1:0] threshold_value;

    // predictor state
    longint unsigned  hist_bins [BINS];
    longint unsigned  frame_pixels;
    longint unsigned  frame_gray;
    logic [7:0]       thr_now;

    pix_result_t      pending_results [$];
    int               mismatches;
    int               requests_sent;
    int               results_seen;
    int               frames_done;
    int               hold_cycles;
    int               rx_gap = 0;
    bit               idle_on;

    otsu_binarize_frame dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .pixel           (pixel),
        .last            (last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .binary_pixel    (binary_pixel),
        .threshold_value (threshold_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(40_000_000);
        $display("** otsu_binarize_frame: FAILED **");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // search thresholds for the largest between-class variance
    function automatic logic [7:0] search_threshold();
        longint unsigned n, sum, wb, sumb, wf, p, q, mag, den, bdiff, bden;
        logic [127:0]    lhs, rhs;
        int              best_t;
        n      = frame_pixels;
        sum    = frame_gray;
        wb     = 0;
        sumb   = 0;
        bdiff  = 0;
        bden   = 0;
        best_t = 0;
        for (int t = 0; t < BINS; t++)
        begin
            wb += hist_bins[t];
            if (wb == 0)
                continue;
            if (wb >= n)
                break;
            wf   = n - wb;
            sumb += longint'(t) * hist_bins[t];
            p    = sumb * n;
            q    = sum * wb;
            mag  = (p >= q) ? p - q : q - p;
            den  = wb * wf;
            if (bdiff == 0)
            begin
                if (mag != 0)
                begin
                    bdiff  = mag;
                    bden   = den;
                    best_t = t;
                end
            end
            else
            begin
                lhs = 128'(mag) * 128'(mag) * 128'(bden);
                rhs = 128'(bdiff) * 128'(bdiff) * 128'(den);
                if (lhs > rhs)
                begin
                    bdiff  = mag;
                    bden   = den;
                    best_t = t;
                end
            end
        end
        for (int i = 0; i < BINS; i++)
            hist_bins[i] = 0;
        frame_pixels = 0;
        frame_gray   = 0;
        return best_t[7:0];
    endfunction

    // update predictor for one accepted request
    task automatic predict_request(input logic op, input logic [7:0] px, input logic lst);
        pix_result_t r;
        if (op == OP_BINARIZE)
        begin
            r.kind            = KIND_PIXEL;
            r.binary_pixel    = (px >= thr_now) ? 8'd255 : 8'd0;
            r.threshold_value = thr_now;
            pending_results.push_back(r);
            return;
        end
        if (frame_pixels < PIXEL_CAP)
        begin
            hist_bins[px] += 1;
            frame_pixels  += 1;
            frame_gray    += px;
        end
        if (lst)
        begin
            thr_now           = search_threshold();
            r.kind            = KIND_THRESHOLD;
            r.binary_pixel    = '0;
            r.threshold_value = thr_now;
            pending_results.push_back(r);
            frames_done++;
        end
    endtask

    // offer one request and hold it until accepted
    task automatic send_request(input logic op, input logic [7:0] px, input logic lst);
        int gap;
        operation <= op;
        pixel     <= px;
        last      <= lst;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_request(op, px, lst);
        requests_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // check results and drive the receiver stall
    always @(posedge clk)
    begin
        pix_result_t e;
        int          r;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result kind=%0d px=%0d thr=%0d",
                                 kind, binary_pixel, threshold_value);
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (e.kind !== kind || e.binary_pixel !== binary_pixel ||
                        e.threshold_value !== threshold_value)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected kind=%0d px=%0d thr=%0d, got kind=%0d px=%0d thr=%0d",
                                     e.kind, e.binary_pixel, e.threshold_value,
                                     kind, binary_pixel, threshold_value);
                    end
                end
            end
        end
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall   <= 1'b1;
        end
        else if (rx_gap > 0)
        begin
            rx_gap    <= rx_gap - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (idle_on && r == 99)
            begin
                rx_gap    <= int'($urandom_range(10, 40));
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= idle_on && (r < 25);
            end
        end
    end

    task automatic send_frame(input int len, input int mode);
        logic [7:0] px;
        logic [7:0] a, b;
        a = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0: px = 8'($urandom_range(0, 255));
                1: px = ($urandom_range(0, 1) ? a : b) ^ 8'($urandom_range(0, 7));
                2: px = $urandom_range(0, 1) ? a : b;
                default: px = a;
            endcase
            send_request(OP_ACCUMULATE, px, i == len - 1);
        end
    endtask

    task automatic test_reset_threshold();
        send_request(OP_BINARIZE, 8'd0, 1'b0);
        send_request(OP_BINARIZE, 8'd255, 1'b1);
    endtask

    task automatic test_directed_frames();
        // extremes plus a mid value
        send_request(OP_ACCUMULATE, 8'd0, 1'b0);
        send_request(OP_ACCUMULATE, 8'd255, 1'b0);
        send_request(OP_ACCUMULATE, 8'd128, 1'b1);
        send_request(OP_BINARIZE, 8'd0, 1'b0);
        send_request(OP_BINARIZE, 8'd127, 1'b0);
        send_request(OP_BINARIZE, 8'd128, 1'b1);
        send_request(OP_BINARIZE, 8'd255, 1'b0);
        // uniform frame
        repeat (4) send_request(OP_ACCUMULATE, 8'd77, 1'b0);
        send_request(OP_ACCUMULATE, 8'd77, 1'b1);
        send_request(OP_BINARIZE, 8'd76, 1'b0);
        // single pixel frame
        send_request(OP_ACCUMULATE, 8'd200, 1'b1);
        // symmetric frame with tied variances
        send_request(OP_ACCUMULATE, 8'd10, 1'b0);
        send_request(OP_ACCUMULATE, 8'd20, 1'b0);
        send_request(OP_ACCUMULATE, 8'd30, 1'b1);
        send_request(OP_BINARIZE, 8'd85, 1'b0);
        send_request(OP_BINARIZE, 8'd170, 1'b0);
    endtask

    task automatic test_random_traffic();
        int start;
        start = requests_sent;
        while (requests_sent - start < 480)
        begin
            idle_on = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 7) == 0)
                send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
            else
                send_frame($urandom_range(3, 30), $urandom_range(0, 3));
            repeat ($urandom_range(3, 20))
                send_request(OP_BINARIZE, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
        end
        idle_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        // receiver holds off while requests pile up
        hold_cycles = 400;
        repeat (40)
            send_request(OP_BINARIZE, 8'($urandom_range(0, 255)), 1'b0);
        send_frame(6, 1);
    endtask

    initial
    begin
        int waited;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = OP_ACCUMULATE;
        pixel         = '0;
        last          = 1'b0;
        out_stall     = 1'b0;
        mismatches    = 0;
        requests_sent = 0;
        results_seen  = 0;
        frames_done   = 0;
        hold_cycles   = 0;
        idle_on       = 1'b1;
        frame_pixels  = 0;
        frame_gray    = 0;
        thr_now       = 8'd0;
        for (int i = 0; i < BINS; i++)
            hist_bins[i] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_threshold();
        test_directed_frames();
        test_output_backpressure();
        test_random_traffic();
        in_valid <= 1'b0;

        // drain outstanding results
        waited = 0;
        while (pending_results.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            $display("%0d results never arrived", pending_results.size());
            mismatches++;
        end
        repeat (100) @(posedge clk);

        $display("Sent %0d requests over %0d frames, checked %0d results.",
                 requests_sent, frames_done, results_seen);
        $display("Covered uniform, tied and single-pixel frames plus long output holds, %0d mismatches.",
                 mismatches);
        if (mismatches == 0)
            $display("** otsu_binarize_frame: PASSED **");
        else
            $display("** otsu_binarize_frame: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
